FILE: design/jgc_pkg.sv
// ----------------------------------------------------------------------------
// jgc_pkg
// Shared types, widths and defaults for the joystick grid cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package jgc_pkg;

  localparam int DISP_W     = 12;
  localparam int SET_W      = 8;
  localparam int CELL_W     = 4;
  localparam int DZ_W       = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 24;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int GRID_ROWS_DEF = 16;
  localparam int GRID_COLS_DEF = 16;
  localparam int MAX_DISP_DEF  = 2048;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [GAIN_W-1:0] STEP_GAIN_RST = GAIN_W'(1229);

  typedef enum logic {
    MODE_TICK,
    MODE_SET
  } jgc_mode_e;

  typedef enum logic {
    REG_DEAD_ZONE,
    REG_STEP_GAIN
  } jgc_reg_e;

  typedef struct packed {
    logic set;    // load a whole-cell location
    logic still;  // both axes inside the dead zone
    logic first;  // first tick outside the dead zone
    logic over;   // this axis reaches the dead zone
  } jgc_axis_ctl_t;

endpackage

`default_nettype wire

FILE: design/jgc_in_if.sv
// ----------------------------------------------------------------------------
// jgc_in_if
// Input channel: tick or set transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface jgc_in_if import jgc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DISP_W-1:0] disp_x;
  logic signed [DISP_W-1:0] disp_y;
  logic signed [SET_W-1:0]  set_row;
  logic signed [SET_W-1:0]  set_col;

  modport source (output valid, mode, disp_x, disp_y, set_row, set_col, input ready);
  modport sink   (input valid, mode, disp_x, disp_y, set_row, set_col, output ready);
endinterface

`default_nettype wire

FILE: design/jgc_out_if.sv
// ----------------------------------------------------------------------------
// jgc_out_if
// Result channel: rounded cursor cell and moving flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface jgc_out_if import jgc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_row;
  logic [CELL_W-1:0] cell_col;
  logic              moving;

  modport source (output valid, cell_row, cell_col, moving, input ready);
  modport sink   (input valid, cell_row, cell_col, moving, output ready);
endinterface

`default_nettype wire

FILE: design/jgc_axis.sv
// ----------------------------------------------------------------------------
// jgc_axis
// Next fixed-point position of one cursor axis: set, snap or move, then clip.
// ----------------------------------------------------------------------------
`default_nettype none

module jgc_axis import jgc_pkg::*; #(
  parameter int GRID      = GRID_ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int POS_W     = $clog2(GRID_ROWS_DEF) + FRAC_BITS_DEF
) (
  input  jgc_axis_ctl_t            ctl_i,
  input  logic [POS_W-1:0]         pos_i,
  input  logic signed [DISP_W-1:0] disp_i,
  input  logic [GAIN_W-1:0]        gain_i,
  input  logic signed [SET_W-1:0]  set_i,
  output logic [POS_W-1:0]         pos_o
);

  localparam int SHIFT  = GAIN_FRAC - FRAC_BITS;
  localparam int PROD_W = DISP_W + GAIN_W + 1;
  localparam int SUM_W  = ((POS_W > PROD_W) ? POS_W : PROD_W) + 2;

  localparam logic [PROD_W-1:0] RND     = PROD_W'((2 ** SHIFT) / 2);
  localparam logic [POS_W-1:0]  HALF    = POS_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0]  POS_MAX = SUM_W'(GRID - 1) << FRAC_BITS;
  localparam logic [SET_W-1:0]  SET_MAX = SET_W'(GRID - 1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [PROD_W-1:0] step;
  logic signed [SUM_W-1:0]  delta;
  logic signed [SUM_W-1:0]  sum;
  logic [POS_W-1:0]         clipped;
  logic [POS_W:0]           snap_sum;
  logic [POS_W-1:0]         snapped;
  logic [SET_W-1:0]         set_clip;
  logic [POS_W-1:0]         set_pos;

  // gain product rounded half up to FRAC_BITS fraction bits
  assign prod     = $signed(PROD_W'(disp_i)) * $signed(PROD_W'({1'b0, gain_i}));
  assign prod_rnd = prod + $signed(RND);
  assign step     = prod_rnd >>> SHIFT;

  always_comb begin
    if (ctl_i.first) begin
      if (!ctl_i.over) begin
        delta = '0;
      end else if (disp_i[DISP_W-1]) begin
        delta = -$signed(SUM_W'(HALF));
      end else begin
        delta = $signed(SUM_W'(HALF));
      end
    end else begin
      delta = SUM_W'(step);
    end
  end

  assign sum = $signed(SUM_W'(pos_i)) + delta;

  always_comb begin
    if (sum[SUM_W-1]) begin
      clipped = '0;
    end else if ($unsigned(sum) > POS_MAX) begin
      clipped = POS_W'(POS_MAX);
    end else begin
      clipped = POS_W'($unsigned(sum));
    end
  end

  assign snap_sum = (POS_W + 1)'(pos_i) + (POS_W + 1)'(HALF);
  assign snapped  = POS_W'((snap_sum >> FRAC_BITS) << FRAC_BITS);

  always_comb begin
    if (set_i[SET_W-1]) begin
      set_clip = '0;
    end else if ($unsigned(set_i) > SET_MAX) begin
      set_clip = SET_MAX;
    end else begin
      set_clip = $unsigned(set_i);
    end
  end

  assign set_pos = POS_W'(set_clip) << FRAC_BITS;

  always_comb begin
    if (ctl_i.set) begin
      pos_o = set_pos;
    end else if (ctl_i.still) begin
      pos_o = snapped;
    end else begin
      pos_o = clipped;
    end
  end

endmodule

`default_nettype wire

FILE: design/joystick_grid_cursor.sv
// ----------------------------------------------------------------------------
// joystick_grid_cursor
// Joystick-driven cursor on a grid with dead zone, snap and gain stepping.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while its result is not
// stalled and returns one result for each: an input register captures the
// transaction, and the per-axis update (one 12x16 multiply, add and clip)
// runs from it into the result register and the position state. A
// stalled result holds the pipeline; the input register keeps accepting until
// it is full. Registers: dead_zone at byte address 0, step_gain at byte 4.
// Reset places the cursor at the grid center, not moving.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_grid_cursor import jgc_pkg::*; #(
  parameter int GRID_ROWS = GRID_ROWS_DEF,
  parameter int GRID_COLS = GRID_COLS_DEF,
  parameter int MAX_DISP  = MAX_DISP_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  jgc_in_if.sink                in_i,
  jgc_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int ROW_W    = $clog2(GRID_ROWS) + FRAC_BITS;
  localparam int COL_W    = $clog2(GRID_COLS) + FRAC_BITS;
  localparam int ROW_SW   = ((ROW_W + 1) > (FRAC_BITS + CELL_W)) ? ROW_W + 1
                                                                  : FRAC_BITS + CELL_W;
  localparam int COL_SW   = ((COL_W + 1) > (FRAC_BITS + CELL_W)) ? COL_W + 1
                                                                  : FRAC_BITS + CELL_W;
  localparam int DZ_RAW   = 3 * MAX_DISP / 4;
  localparam int DZ_CAP   = (2 ** DZ_W) - 1;
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = DZ_W'((DZ_RAW > DZ_CAP) ? DZ_CAP : DZ_RAW);
  localparam logic [ROW_W-1:0] ROW_RST  = ROW_W'(GRID_ROWS / 2) << FRAC_BITS;
  localparam logic [COL_W-1:0] COL_RST  = COL_W'(GRID_COLS / 2) << FRAC_BITS;
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(GRID_ROWS - 1) << FRAC_BITS;
  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(GRID_COLS - 1) << FRAC_BITS;

  // configuration
  logic [DZ_W-1:0]   dead_zone_q;
  logic [GAIN_W-1:0] step_gain_q;
  logic              cfg_wr;
  jgc_reg_e          cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = jgc_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= DEAD_ZONE_RST;
      step_gain_q <= STEP_GAIN_RST;
    end else if (cfg_wr) begin
      case (cfg_reg)
        REG_DEAD_ZONE: dead_zone_q <= pwdata[DZ_W-1:0];
        REG_STEP_GAIN: step_gain_q <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg)
      REG_DEAD_ZONE: prdata = APB_DATA_W'(dead_zone_q);
      REG_STEP_GAIN: prdata = APB_DATA_W'(step_gain_q);
      default:       prdata = '0;
    endcase
  end

  // input register
  logic                     s1_valid_q;
  jgc_mode_e                s1_mode_q;
  logic signed [DISP_W-1:0] s1_disp_x_q;
  logic signed [DISP_W-1:0] s1_disp_y_q;
  logic signed [SET_W-1:0]  s1_set_row_q;
  logic signed [SET_W-1:0]  s1_set_col_q;
  logic                     advance;
  logic                     in_take;

  logic              res_valid_q;
  logic [CELL_W-1:0] res_row_q;
  logic [CELL_W-1:0] res_col_q;
  logic              res_moving_q;

  assign advance    = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q    <= jgc_mode_e'(in_i.mode);
      s1_disp_x_q  <= in_i.disp_x;
      s1_disp_y_q  <= in_i.disp_y;
      s1_set_row_q <= in_i.set_row;
      s1_set_col_q <= in_i.set_col;
    end
  end

  // update
  logic [ROW_W-1:0]  row_pos_q, row_pos_d;
  logic [COL_W-1:0]  col_pos_q, col_pos_d;
  logic              was_moving_q, was_moving_d;
  logic [DISP_W-1:0] mag_x, mag_y;
  logic              over_x, over_y, is_set, still, moving_d;
  jgc_axis_ctl_t     row_ctl, col_ctl;
  logic [ROW_SW-1:0] row_rnd;
  logic [COL_SW-1:0] col_rnd;

  assign mag_x  = s1_disp_x_q[DISP_W-1] ? DISP_W'(-s1_disp_x_q) : s1_disp_x_q;
  assign mag_y  = s1_disp_y_q[DISP_W-1] ? DISP_W'(-s1_disp_y_q) : s1_disp_y_q;
  assign over_x = mag_x >= dead_zone_q;
  assign over_y = mag_y >= dead_zone_q;
  assign is_set = s1_mode_q == MODE_SET;
  assign still  = !over_x && !over_y;

  assign moving_d     = !is_set && !still;
  assign was_moving_d = is_set ? was_moving_q : !still;

  assign row_ctl = '{set: is_set, still: still, first: !was_moving_q, over: over_y};
  assign col_ctl = '{set: is_set, still: still, first: !was_moving_q, over: over_x};

  jgc_axis #(
    .GRID      (GRID_ROWS),
    .FRAC_BITS (FRAC_BITS),
    .POS_W     (ROW_W)
  ) u_row (
    .ctl_i  (row_ctl),
    .pos_i  (row_pos_q),
    .disp_i (s1_disp_y_q),
    .gain_i (step_gain_q),
    .set_i  (s1_set_row_q),
    .pos_o  (row_pos_d)
  );

  jgc_axis #(
    .GRID      (GRID_COLS),
    .FRAC_BITS (FRAC_BITS),
    .POS_W     (COL_W)
  ) u_col (
    .ctl_i  (col_ctl),
    .pos_i  (col_pos_q),
    .disp_i (s1_disp_x_q),
    .gain_i (step_gain_q),
    .set_i  (s1_set_col_q),
    .pos_o  (col_pos_d)
  );

  assign row_rnd = ROW_SW'(row_pos_d) + (ROW_SW'(1) << (FRAC_BITS - 1));
  assign col_rnd = COL_SW'(col_pos_d) + (COL_SW'(1) << (FRAC_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pos_q    <= ROW_RST;
      col_pos_q    <= COL_RST;
      was_moving_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        row_pos_q    <= row_pos_d;
        col_pos_q    <= col_pos_d;
        was_moving_q <= was_moving_d;
        res_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_row_q    <= row_rnd[FRAC_BITS +: CELL_W];
      res_col_q    <= col_rnd[FRAC_BITS +: CELL_W];
      res_moving_q <= moving_d;
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.cell_row = res_row_q;
  assign out_o.cell_col = res_col_q;
  assign out_o.moving   = res_moving_q;

  // checks
  a_row_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_pos_q <= ROW_MAX)
    else $error("row position beyond grid");

  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_pos_q <= COL_MAX)
    else $error("column position beyond grid");

  a_set_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_set) |=> (!res_moving_q && $stable(was_moving_q)))
    else $error("set transaction changed motion state");

  a_snap_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_set && still) |=>
      (row_pos_q[FRAC_BITS-1:0] == '0 && col_pos_q[FRAC_BITS-1:0] == '0 && !was_moving_q))
    else $error("still tick left a fractional position");

  a_rose_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(was_moving_q) |-> (res_valid_q && res_moving_q))
    else $error("motion state set without a moving result");

endmodule

`default_nettype wire
